// ----- sv/heading_pid_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Heading PID controller assertion macros
// Shared macros for the concurrent checks on the controller ports.
// ----------------------------------------------------------------------------
`ifndef HEADING_PID_CONTROLLER_DEFINES_SVH
`define HEADING_PID_CONTROLLER_DEFINES_SVH

// Check on every rising edge of clk, held off while rst_n is low.
`define HPID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hpid: checker property failed");

// Check on every rising edge of clk, including while in reset.
`define HPID_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hpid: checker property failed");

`endif

// ----- sv/hpid_pkg.sv -----
// ----------------------------------------------------------------------------
// Heading PID controller package
// Register map, configuration type and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpid_pkg;

    localparam int HeadingW = 9;
    localparam int DataW    = 32;
    localparam int PoleW    = 18;
    localparam int FracW    = 16;
    localparam int CfgIdxW  = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INT_GAIN   = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_DERIV_POLE = 3'd3,
        REG_OUT_MIN    = 3'd4,
        REG_OUT_MAX    = 3'd5,
        REG_INT_MIN    = 3'd6,
        REG_INT_MAX    = 3'd7
    } hpid_reg_t;

    typedef struct packed {
        logic signed [DataW-1:0] prop_gain;
        logic signed [DataW-1:0] int_gain;
        logic signed [DataW-1:0] deriv_gain;
        logic signed [PoleW-1:0] deriv_pole;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
        logic signed [DataW-1:0] int_min;
        logic signed [DataW-1:0] int_max;
    } hpid_cfg_t;

    localparam logic signed [DataW-1:0] DATA_MIN = {1'b1, {(DataW-1){1'b0}}};
    localparam logic signed [DataW-1:0] DATA_MAX = {1'b0, {(DataW-1){1'b1}}};

    localparam logic signed [10:0] HALF_TURN = 11'sd180;
    localparam logic signed [10:0] FULL_TURN = 11'sd360;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
        logic signed [DataW-1:0] r;
        if (v > 64'(DATA_MAX)) begin
            r = DATA_MAX;
        end
        else if (v < 64'(DATA_MIN)) begin
            r = DATA_MIN;
        end
        else begin
            r = v[DataW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DataW-1:0] clamp_lim(
        input logic signed [DataW-1:0] v,
        input logic signed [DataW-1:0] lo,
        input logic signed [DataW-1:0] hi
    );
        logic signed [DataW-1:0] r;
        if (v > hi) begin
            r = hi;
        end
        else if (v < lo) begin
            r = lo;
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/hpid_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Heading PID controller configuration registers
// Holds gains, filter pole and clamp limits written over the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpid_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [hpid_pkg::CfgIdxW-1:0] wr_index,
    input  logic [hpid_pkg::DataW-1:0]  wr_data,
    output hpid_pkg::hpid_cfg_t         cfg
);
    import hpid_pkg::*;

    hpid_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain  <= '0;
            cfg_reg.int_gain   <= '0;
            cfg_reg.deriv_gain <= '0;
            cfg_reg.deriv_pole <= '0;
            cfg_reg.out_min    <= DATA_MIN;
            cfg_reg.out_max    <= DATA_MAX;
            cfg_reg.int_min    <= DATA_MIN;
            cfg_reg.int_max    <= DATA_MAX;
        end
        else if (wr_en)
        begin
            unique case (hpid_reg_t'(wr_index))
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= wr_data;
                REG_INT_GAIN:   cfg_reg.int_gain   <= wr_data;
                REG_DERIV_GAIN: cfg_reg.deriv_gain <= wr_data;
                REG_DERIV_POLE: cfg_reg.deriv_pole <= wr_data[PoleW-1:0];
                REG_OUT_MIN:    cfg_reg.out_min    <= wr_data;
                REG_OUT_MAX:    cfg_reg.out_max    <= wr_data;
                REG_INT_MIN:    cfg_reg.int_min    <= wr_data;
                REG_INT_MAX:    cfg_reg.int_max    <= wr_data;
                default:        cfg_reg.prop_gain  <= cfg_reg.prop_gain;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/heading_pid_controller.sv -----
// ----------------------------------------------------------------------------
// Heading PID controller
// Steers toward a compass heading: wrapped heading error, proportional term,
// clamped trapezoidal integral and band-limited derivative on the measurement.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------
//   input     in_valid / in_stall  target_heading, measured_heading
//   output    out_valid / out_stall drive
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is taken every cycle while in_stall is low; each drive value
// passes the s1, s2 and s3 stage registers and then the output register.
// The integrator and derivative filter close their loops in the third stage,
// whose path is the pole multiply followed by the rounding add and saturation.
// Reset clears the pipeline, the controller state and returns the registers to defaults.
// An output stall holds the result; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heading_pid_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hpid_pkg::HeadingW-1:0] target_heading,
    input  logic [hpid_pkg::HeadingW-1:0] measured_heading,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [hpid_pkg::DataW-1:0] drive,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hpid_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hpid_pkg::DataW-1:0]    cfg_data
);
    import hpid_pkg::*;

    hpid_cfg_t cfg;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic rdy_s1;
    logic rdy_s2;
    logic rdy_s3;
    logic rdy_out;
    logic move_s1;
    logic move_s2;
    logic move_s3;
    logic move_out;

    logic [HeadingW-1:0] s1_tgt_reg;
    logic [HeadingW-1:0] s1_meas_reg;

    logic signed [HeadingW-1:0] last_error_reg;
    logic [HeadingW-1:0]        last_heading_reg;
    logic signed [DataW-1:0]    integral_acc_reg;
    logic signed [DataW-1:0]    deriv_acc_reg;

    logic signed [DataW-1:0] s2_p_reg;
    logic signed [41:0]      s2_iprod_reg;
    logic signed [41:0]      s2_dprod_reg;
    logic signed [DataW-1:0] s3_p_reg;
    logic signed [DataW-1:0] drive_reg;

    logic signed [10:0]         diff;
    logic signed [10:0]         err_wide;
    logic signed [HeadingW-1:0] err;
    logic signed [HeadingW:0]   err_sum;
    logic signed [HeadingW:0]   meas_delta;
    logic signed [40:0]         pprod;
    logic signed [41:0]         iprod;
    logic signed [41:0]         dprod;
    logic signed [DataW-1:0]    s2_p_next;

    logic signed [49:0]      fb_prod;
    logic signed [49:0]      fb_round;
    logic signed [49:0]      fb_shift;
    logic signed [63:0]      i_sum;
    logic signed [63:0]      d_sum;
    logic signed [DataW-1:0] integral_acc_next;
    logic signed [DataW-1:0] deriv_acc_next;

    logic signed [63:0]      y_sum;
    logic signed [DataW-1:0] drive_next;

    assign cfg_ready = 1'b1;

    hpid_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy_s3   = !s3_valid_reg || rdy_out;
    assign rdy_s2   = !s2_valid_reg || rdy_s3;
    assign rdy_s1   = !s1_valid_reg || rdy_s2;
    assign in_stall = !rdy_s1;

    assign move_s1  = in_valid && rdy_s1;
    assign move_s2  = s1_valid_reg && rdy_s2;
    assign move_s3  = s2_valid_reg && rdy_s3;
    assign move_out = s3_valid_reg && rdy_out;

    always_comb
    begin
        diff = $signed({2'b00, s1_tgt_reg}) - $signed({2'b00, s1_meas_reg});
        if (diff > HALF_TURN)
        begin
            err_wide = diff - FULL_TURN;
        end
        else if (diff < -HALF_TURN)
        begin
            err_wide = diff + FULL_TURN;
        end
        else
        begin
            err_wide = diff;
        end
        err        = err_wide[HeadingW-1:0];
        err_sum    = (HeadingW+1)'(err) + (HeadingW+1)'(last_error_reg);
        meas_delta = $signed({1'b0, s1_meas_reg}) - $signed({1'b0, last_heading_reg});
        pprod      = 41'(cfg.prop_gain) * 41'(err);
        iprod      = 42'(cfg.int_gain) * 42'(err_sum);
        dprod      = 42'(cfg.deriv_gain) * 42'(meas_delta);
        s2_p_next  = sat32(64'(pprod));
    end

    always_comb
    begin
        i_sum             = 64'(integral_acc_reg) + 64'(s2_iprod_reg);
        integral_acc_next = clamp_lim(sat32(i_sum), cfg.int_min, cfg.int_max);
        fb_prod           = 50'(cfg.deriv_pole) * 50'(deriv_acc_reg);
        fb_round          = fb_prod + 50'sd32768;
        fb_shift          = fb_round >>> FracW;
        d_sum             = 64'(fb_shift) - 64'(s2_dprod_reg);
        deriv_acc_next    = sat32(d_sum);
    end

    always_comb
    begin
        y_sum      = 64'(s3_p_reg) + 64'(integral_acc_reg) + 64'(deriv_acc_reg);
        drive_next = clamp_lim(sat32(y_sum), cfg.out_min, cfg.out_max);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_error_reg   <= '0;
            last_heading_reg <= '0;
            integral_acc_reg <= '0;
            deriv_acc_reg    <= '0;
        end
        else
        begin
            if (rdy_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (move_s2)
            begin
                last_error_reg   <= err;
                last_heading_reg <= s1_meas_reg;
            end
            if (move_s3)
            begin
                integral_acc_reg <= integral_acc_next;
                deriv_acc_reg    <= deriv_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_s1)
        begin
            s1_tgt_reg  <= target_heading;
            s1_meas_reg <= measured_heading;
        end
        if (move_s2)
        begin
            s2_p_reg     <= s2_p_next;
            s2_iprod_reg <= iprod;
            s2_dprod_reg <= dprod;
        end
        if (move_s3)
        begin
            s3_p_reg <= s2_p_reg;
        end
        if (move_out)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

// ----- sv/hpid_checker.sv -----
// ----------------------------------------------------------------------------
// Heading PID controller port checker
// Concurrent checks on the controller ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heading_pid_controller_defines.svh"

module hpid_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [hpid_pkg::DataW-1:0]    drive,
    input logic                          cfg_ready
);

    // A held result keeps its value until it is transferred.
    `HPID_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(drive))

    // No result is offered while reset is applied.
    `HPID_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid)

    // The register port never pushes back.
    `HPID_ASSERT(a_cfg_ready, cfg_ready)

    // With a free output, an accepted sample shows its result once through the pipeline.
    `HPID_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)

endmodule

bind heading_pid_controller hpid_checker u_hpid_checker (.*);

// ----- tb/sv/tb_heading_pid_controller.sv -----
// ----------------------------------------------------------------------------
// Heading PID controller testbench
// Drives heading samples and register writes into the controller with random
// gaps and output stalls, predicts every drive value with a behavioral model of
// the controller, and compares each output transfer against the oldest
// pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heading_pid_controller;
    import hpid_pkg::*;

    localparam int     ClkPeriod    = 10;
    localparam int     ResetCycles  = 8;
    localparam int     MaxReported  = 10;
    localparam int     RandomPhases = 10;
    localparam int     PhaseItems   = 130;
    localparam int     DrainCycles  = 20;
    localparam longint RunLimitNs   = 5_000_000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [HeadingW-1:0]     target_heading;
    logic [HeadingW-1:0]     measured_heading;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [DataW-1:0] drive;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxW-1:0]      cfg_index;
    logic [DataW-1:0]        cfg_data;

    hpid_cfg_t               model_cfg;
    logic signed [DataW-1:0] integ_acc;
    logic signed [DataW-1:0] filt_acc;
    logic signed [HeadingW-1:0] prev_err;
    logic [HeadingW-1:0]     prev_meas;

    logic signed [DataW-1:0] pending_drive[$];
    logic signed [DataW-1:0] want_drive;
    int                      error_count = 0;
    bit                      idle_on;

    heading_pid_controller i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .target_heading   (target_heading),
        .measured_heading (measured_heading),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive            (drive),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    initial
    begin
        #(RunLimitNs);
        $display("Some tests failed");
        $finish;
    end

    function automatic longint clip32(input longint v);
        if (v > longint'(DATA_MAX))
        begin
            return longint'(DATA_MAX);
        end
        if (v < longint'(DATA_MIN))
        begin
            return longint'(DATA_MIN);
        end
        return v;
    endfunction

    function automatic longint limit_to(input longint v, input longint lo, input longint hi);
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [DataW-1:0] compute_drive(
        input logic [HeadingW-1:0] tgt,
        input logic [HeadingW-1:0] meas
    );
        longint err;
        longint prop;
        longint integ;
        longint fb;
        longint deriv;
        longint y;
        err = longint'(tgt) - longint'(meas);
        if (err > longint'(HALF_TURN))
        begin
            err = err - longint'(FULL_TURN);
        end
        else if (err < -longint'(HALF_TURN))
        begin
            err = err + longint'(FULL_TURN);
        end
        prop = clip32(longint'($signed(model_cfg.prop_gain)) * err);
        integ = clip32(longint'(integ_acc)
                       + longint'($signed(model_cfg.int_gain)) * (err + longint'(prev_err)));
        integ = limit_to(integ, longint'($signed(model_cfg.int_min)),
                         longint'($signed(model_cfg.int_max)));
        fb = (longint'($signed(model_cfg.deriv_pole)) * longint'(filt_acc)
              + (64'sd1 <<< (FracW - 1))) >>> FracW;
        deriv = clip32(fb - longint'($signed(model_cfg.deriv_gain))
                       * (longint'(meas) - longint'(prev_meas)));
        y = clip32(prop + integ + deriv);
        y = limit_to(y, longint'($signed(model_cfg.out_min)),
                     longint'($signed(model_cfg.out_max)));
        integ_acc = integ[DataW-1:0];
        filt_acc  = deriv[DataW-1:0];
        prev_err  = err[HeadingW-1:0];
        prev_meas = meas;
        return y[DataW-1:0];
    endfunction

    function automatic void apply_reg(input hpid_reg_t idx, input logic [DataW-1:0] value);
        case (idx)
            REG_PROP_GAIN:  model_cfg.prop_gain  = value;
            REG_INT_GAIN:   model_cfg.int_gain   = value;
            REG_DERIV_GAIN: model_cfg.deriv_gain = value;
            REG_DERIV_POLE: model_cfg.deriv_pole = value[PoleW-1:0];
            REG_OUT_MIN:    model_cfg.out_min    = value;
            REG_OUT_MAX:    model_cfg.out_max    = value;
            REG_INT_MIN:    model_cfg.int_min    = value;
            REG_INT_MAX:    model_cfg.int_max    = value;
            default:        ;
        endcase
    endfunction

    function automatic void reset_model();
        model_cfg.prop_gain  = '0;
        model_cfg.int_gain   = '0;
        model_cfg.deriv_gain = '0;
        model_cfg.deriv_pole = '0;
        model_cfg.out_min    = DATA_MIN;
        model_cfg.out_max    = DATA_MAX;
        model_cfg.int_min    = DATA_MIN;
        model_cfg.int_max    = DATA_MAX;
        integ_acc = '0;
        filt_acc  = '0;
        prev_err  = '0;
        prev_meas = '0;
    endfunction

    function automatic int pick_idle();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [DataW-1:0] pick_gain();
        case ($urandom_range(9))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return $urandom();
            default: return $urandom_range(8 << FracW) - (4 << FracW);
        endcase
    endfunction

    function automatic logic [DataW-1:0] pick_pole();
        logic [DataW-1:0] v;
        case ($urandom_range(7))
            0:       v = 32'h0001_0000;
            1:       v = 32'hFFFF_0000;
            2:       v = $urandom();
            default: v = $urandom_range(2 << FracW) - (1 << FracW);
        endcase
        v[DataW-1:PoleW] = (DataW - PoleW)'($urandom());
        return v;
    endfunction

    task automatic pick_limits(output logic [DataW-1:0] lo, output logic [DataW-1:0] hi);
        int a;
        int b;
        case ($urandom_range(5))
            0:
            begin
                lo = DATA_MIN;
                hi = DATA_MAX;
            end
            1:
            begin
                lo = $urandom();
                hi = $urandom();
            end
            default:
            begin
                a  = $urandom_range(400 << FracW);
                b  = $urandom_range(400 << FracW);
                lo = -a;
                hi = b;
                if ($urandom_range(4) == 0)
                begin
                    lo = b;
                    hi = -a;
                end
            end
        endcase
    endtask

    // Output side: random stall bursts, sampled by the checker at the falling edge.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_idle();
            if (n == 0)
            begin
                @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                repeat (n)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drive.size() == 0)
            begin
                error_count++;
                if (error_count <= MaxReported)
                begin
                    $display("unexpected drive transfer: got %0d", drive);
                end
            end
            else
            begin
                want_drive = pending_drive.pop_front();
                if (drive !== want_drive)
                begin
                    error_count++;
                    if (error_count <= MaxReported)
                    begin
                        $display("drive mismatch: expected %0d, got %0d", want_drive, drive);
                    end
                end
            end
        end
    end

    // All tasks below are entered and left at a rising clock edge.
    task automatic send_headings(input logic [HeadingW-1:0] tgt, input logic [HeadingW-1:0] meas);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        target_heading   <= tgt;
        measured_heading <= meas;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        pending_drive.push_back(compute_drive(tgt, meas));
    endtask

    task automatic write_reg(input hpid_reg_t idx, input logic [DataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge clk);
    endtask

    task automatic write_config(
        input logic [DataW-1:0] prop_gain,
        input logic [DataW-1:0] int_gain,
        input logic [DataW-1:0] deriv_gain,
        input logic [DataW-1:0] deriv_pole,
        input logic [DataW-1:0] out_min,
        input logic [DataW-1:0] out_max,
        input logic [DataW-1:0] int_min,
        input logic [DataW-1:0] int_max
    );
        write_reg(REG_PROP_GAIN, prop_gain);
        write_reg(REG_INT_GAIN, int_gain);
        write_reg(REG_DERIV_GAIN, deriv_gain);
        write_reg(REG_DERIV_POLE, deriv_pole);
        write_reg(REG_OUT_MIN, out_min);
        write_reg(REG_OUT_MAX, out_max);
        write_reg(REG_INT_MIN, int_min);
        write_reg(REG_INT_MAX, int_max);
    endtask

    task automatic randomize_config();
        logic [DataW-1:0] lo;
        logic [DataW-1:0] hi;
        write_reg(REG_PROP_GAIN, pick_gain());
        write_reg(REG_INT_GAIN, pick_gain());
        write_reg(REG_DERIV_GAIN, pick_gain());
        write_reg(REG_DERIV_POLE, pick_pole());
        pick_limits(lo, hi);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        pick_limits(lo, hi);
        write_reg(REG_INT_MIN, lo);
        write_reg(REG_INT_MAX, hi);
    endtask

    // With unit proportional gain (1.0 in Q16.16) the drive is the wrapped heading error scaled by 2^16.
    task automatic test_wrap_and_range();
        send_headings(359, 0);
        wait_idle();
        write_reg(REG_PROP_GAIN, 32'h0001_0000);
        send_headings(0, 0);
        send_headings(359, 0);
        send_headings(0, 359);
        send_headings(180, 0);
        send_headings(0, 180);
        send_headings(181, 0);
        send_headings(0, 181);
        send_headings(511, 0);
        send_headings(0, 511);
        send_headings(511, 511);
        send_headings(300, 60);
    endtask

    task automatic test_integrator_limits();
        wait_idle();
        write_reg(REG_PROP_GAIN, '0);
        write_reg(REG_INT_GAIN, 32'h0000_8000);
        write_reg(REG_INT_MAX, 100 * 65536);
        write_reg(REG_INT_MIN, -50 * 65536);
        send_headings(180, 0);
        send_headings(180, 0);
        send_headings(0, 180);
        wait_idle();
        write_reg(REG_INT_MIN, 10 * 65536);
        write_reg(REG_INT_MAX, -10 * 65536);
        send_headings(0, 90);
        wait_idle();
        write_reg(REG_INT_MIN, DATA_MIN);
        write_reg(REG_INT_MAX, DATA_MAX);
        write_reg(REG_INT_GAIN, DATA_MAX);
        send_headings(180, 0);
        send_headings(180, 0);
    endtask

    task automatic test_derivative_filter();
        wait_idle();
        write_reg(REG_INT_GAIN, '0);
        write_reg(REG_INT_MIN, '0);
        write_reg(REG_INT_MAX, '0);
        write_reg(REG_DERIV_GAIN, 32'h0001_0000);
        write_reg(REG_DERIV_POLE, 32'h0001_0000);
        send_headings(0, 10);
        send_headings(0, 40);
        wait_idle();
        write_reg(REG_DERIV_POLE, 32'hFFFF_0000);
        send_headings(0, 0);
        wait_idle();
        write_reg(REG_DERIV_POLE, 32'hABC1_FFFF);
        write_reg(REG_DERIV_GAIN, 32'd1);
        send_headings(0, 511);
    endtask

    task automatic test_output_clamp();
        wait_idle();
        write_reg(REG_DERIV_GAIN, '0);
        write_reg(REG_DERIV_POLE, '0);
        write_reg(REG_PROP_GAIN, DATA_MAX);
        send_headings(180, 0);
        wait_idle();
        write_reg(REG_PROP_GAIN, DATA_MIN);
        write_reg(REG_OUT_MIN, -1000 * 65536);
        write_reg(REG_OUT_MAX, 1000 * 65536);
        send_headings(180, 0);
        wait_idle();
        write_reg(REG_OUT_MIN, 5 * 65536);
        write_reg(REG_OUT_MAX, -5 * 65536);
        send_headings(0, 0);
        send_headings(180, 0);
    endtask

    // Mostly a measured heading that drifts around a target, with some
    // uniform and out-of-range samples mixed in.
    task automatic test_random_sequences();
        int tgt;
        int meas;
        int mode;
        int step;
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            wait_idle();
            if (phase == 0)
            begin
                write_config(DATA_MAX, DATA_MAX, DATA_MAX, 32'h0001_0000,
                             DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
            end
            else if (phase == 1)
            begin
                write_config(DATA_MIN, DATA_MIN, DATA_MIN, 32'hFFFF_0000,
                             DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
            end
            else
            begin
                randomize_config();
            end
            idle_on = (phase % 4 != 3);
            mode = $urandom_range(9);
            tgt  = $urandom_range(359);
            meas = $urandom_range(359);
            for (int k = 0; k < PhaseItems; k++)
            begin
                if (mode < 6)
                begin
                    if ($urandom_range(15) == 0)
                    begin
                        tgt = $urandom_range(359);
                    end
                    step = int'($urandom_range(12)) - 6;
                    meas = (meas + step + 360) % 360;
                end
                else if (mode < 9)
                begin
                    tgt  = $urandom_range(359);
                    meas = $urandom_range(359);
                end
                else
                begin
                    tgt  = $urandom_range(511);
                    meas = $urandom_range(511);
                end
                if ($urandom_range(19) == 0)
                begin
                    tgt = $urandom_range(511);
                end
                if ($urandom_range(19) == 0)
                begin
                    meas = $urandom_range(511);
                end
                send_headings(tgt, meas);
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        target_heading   <= '0;
        measured_heading <= '0;
        cfg_valid        <= 1'b0;
        cfg_index        <= REG_PROP_GAIN;
        cfg_data         <= '0;
        idle_on = 1'b1;
        reset_model();
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_wrap_and_range();
        test_integrator_limits();
        test_derivative_filter();
        test_output_clamp();
        test_random_sequences();

        wait_idle();
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/hpid_pkg.sv
sv/hpid_cfg_regs.sv
sv/heading_pid_controller.sv
sv/hpid_checker.sv
tb/sv/tb_heading_pid_controller.sv
